@@ rtl/pixel_control_stream_parser_macros.svh @@
// Assertion macros shared by the pixel control stream parser RTL.
`ifndef PIXEL_CONTROL_STREAM_PARSER_MACROS_SVH
`define PIXEL_CONTROL_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pcsp_pkg.sv @@
// Types and constants of the pixel control stream parser.
`timescale 1ns / 1ps
package pcsp_pkg;

    localparam int MAX_LEDS       = 1024;
    localparam int LED_CNT_W      = 11;
    localparam int PIX_IDX_W      = 10;
    localparam int LEN_W          = 16;
    localparam int MSG_CNT_W      = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;

    localparam logic [LED_CNT_W-1:0] LED_LIMIT_MAX = LED_CNT_W'(MAX_LEDS);
    localparam logic [LED_CNT_W-1:0] LED_CNT_SAT   = {LED_CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_COUNT   = 2'd0,
        CFG_SLOT_FIRST  = 2'd1,
        CFG_SLOT_SECOND = 2'd2,
        CFG_SLOT_THIRD  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        SLOT_RED   = 2'd0,
        SLOT_GREEN = 2'd1,
        SLOT_BLUE  = 2'd2,
        SLOT_NONE  = 2'd3
    } t_slot;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_BAD_CMD  = 2'd1,
        ST_BAD_CHAN = 2'd2
    } t_msg_status;

    typedef enum logic [2:0] {
        HDR_CHANNEL = 3'd0,
        HDR_COMMAND = 3'd1,
        HDR_LEN_HI  = 3'd2,
        HDR_LEN_LO  = 3'd3,
        HDR_PAYLOAD = 3'd4
    } t_hdr_pos;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_item;

    typedef struct packed {
        logic                 pixel_valid;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic                 message_done;
        t_msg_status          message_status;
        logic [MSG_CNT_W-1:0] accepted_messages;
    } t_result;

endpackage

@@ rtl/pcsp_byte_if.sv @@
// Byte stream channel: valid/ready handshake with one data byte.
`timescale 1ns / 1ps
interface pcsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/pcsp_result_if.sv @@
// Result channel: valid/ready handshake with pixel write and message status.
`timescale 1ns / 1ps
interface pcsp_result_if;
    logic                            valid;
    logic                            ready;
    logic                            pixel_valid;
    logic [pcsp_pkg::PIX_IDX_W-1:0]  pixel_index;
    logic [7:0]                      red;
    logic [7:0]                      green;
    logic [7:0]                      blue;
    logic                            message_done;
    pcsp_pkg::t_msg_status           message_status;
    logic [pcsp_pkg::MSG_CNT_W-1:0]  accepted_messages;

    modport source (
        output valid, output pixel_valid, output pixel_index, output red,
        output green, output blue, output message_done, output message_status,
        output accepted_messages, input ready
    );
    modport sink (
        input valid, input pixel_valid, input pixel_index, input red,
        input green, input blue, input message_done, input message_status,
        input accepted_messages, output ready
    );
endinterface

@@ rtl/pcsp_in_reg.sv @@
// Input register of the byte stream.
`timescale 1ns / 1ps
module pcsp_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pcsp_byte_if.sink            i_byte,
    input  logic                 i_take,
    output pcsp_pkg::t_byte_item o_item
);
    import pcsp_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       w_load;

    assign i_byte.ready = !r_valid || i_take;
    assign w_load       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_byte.data_byte;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;
endmodule

@@ rtl/pcsp_parser.sv @@
// Message parser: header tracking, color assembly, pixel and status results.
`timescale 1ns / 1ps
module pcsp_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcsp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  pcsp_pkg::t_byte_item               i_item,
    input  logic                               i_advance,
    output logic                               o_take,
    output logic                               o_res_valid,
    output pcsp_pkg::t_result                  o_res
);
    import pcsp_pkg::*;

    logic [LED_CNT_W-1:0] r_led_limit;
    t_slot                r_slot [3];

    t_hdr_pos             r_hdr_pos, n_hdr_pos;
    logic                 r_cmd_bad, n_cmd_bad;
    logic                 r_chan_bad, n_chan_bad;
    logic [LEN_W-1:0]     r_remaining, n_remaining;
    logic [1:0]           r_byte_in_led, n_byte_in_led;
    logic [LED_CNT_W-1:0] r_led_cnt, n_led_cnt;
    logic [23:0]          r_partial, n_partial;
    logic [MSG_CNT_W-1:0] r_msg_cnt, n_msg_cnt;

    logic                 w_finish;
    t_msg_status          w_status;
    t_slot                w_slot;
    logic [7:0]           w_b;

    assign o_take = i_item.valid && i_advance;
    assign w_b    = i_item.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_limit <= '0;
            r_slot[0]   <= SLOT_RED;
            r_slot[1]   <= SLOT_GREEN;
            r_slot[2]   <= SLOT_BLUE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LED_COUNT: begin
                    r_led_limit <= (i_cfg_data > LED_LIMIT_MAX) ? LED_LIMIT_MAX
                                                                : i_cfg_data;
                end
                CFG_SLOT_FIRST:  r_slot[0] <= t_slot'(i_cfg_data[1:0]);
                CFG_SLOT_SECOND: r_slot[1] <= t_slot'(i_cfg_data[1:0]);
                CFG_SLOT_THIRD:  r_slot[2] <= t_slot'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos     <= HDR_CHANNEL;
            r_cmd_bad     <= 1'b0;
            r_chan_bad    <= 1'b0;
            r_remaining   <= '0;
            r_byte_in_led <= '0;
            r_led_cnt     <= '0;
            r_partial     <= '0;
            r_msg_cnt     <= '0;
        end else if (o_take) begin
            r_hdr_pos     <= n_hdr_pos;
            r_cmd_bad     <= n_cmd_bad;
            r_chan_bad    <= n_chan_bad;
            r_remaining   <= n_remaining;
            r_byte_in_led <= n_byte_in_led;
            r_led_cnt     <= n_led_cnt;
            r_partial     <= n_partial;
            r_msg_cnt     <= n_msg_cnt;
        end
    end

    always_comb begin
        n_hdr_pos     = r_hdr_pos;
        n_cmd_bad     = r_cmd_bad;
        n_chan_bad    = r_chan_bad;
        n_remaining   = r_remaining;
        n_byte_in_led = r_byte_in_led;
        n_led_cnt     = r_led_cnt;
        n_partial     = r_partial;
        n_msg_cnt     = r_msg_cnt;
        w_finish      = 1'b0;
        w_slot        = SLOT_NONE;
        o_res         = '0;

        priority if (r_cmd_bad) begin
            w_status = ST_BAD_CMD;
        end else if (r_chan_bad) begin
            w_status = ST_BAD_CHAN;
        end else begin
            w_status = ST_ACCEPTED;
        end

        unique case (r_hdr_pos)
            HDR_CHANNEL: begin
                n_chan_bad = (w_b != 8'd0);
                n_hdr_pos  = HDR_COMMAND;
            end
            HDR_COMMAND: begin
                n_cmd_bad = (w_b != 8'd0);
                n_hdr_pos = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
                n_remaining = {w_b, 8'd0};
                n_hdr_pos   = HDR_LEN_LO;
            end
            HDR_LEN_LO: begin
                n_remaining   = {r_remaining[15:8], w_b};
                n_byte_in_led = '0;
                n_led_cnt     = '0;
                n_partial     = '0;
                n_hdr_pos     = HDR_PAYLOAD;
                w_finish      = ({r_remaining[15:8], w_b} == '0);
            end
            HDR_PAYLOAD: begin
                if (w_status == ST_ACCEPTED) begin
                    n_partial = (r_byte_in_led == 2'd0) ? 24'd0 : r_partial;
                    unique case (r_byte_in_led)
                        2'd0:    w_slot = r_slot[0];
                        2'd1:    w_slot = r_slot[1];
                        default: w_slot = r_slot[2];
                    endcase
                    unique case (w_slot)
                        SLOT_RED:   n_partial[7:0]   = w_b;
                        SLOT_GREEN: n_partial[15:8]  = w_b;
                        SLOT_BLUE:  n_partial[23:16] = w_b;
                        SLOT_NONE:  ;
                    endcase
                    if (r_byte_in_led == 2'd2) begin
                        n_byte_in_led = '0;
                        if (r_led_cnt < r_led_limit) begin
                            o_res.pixel_valid = 1'b1;
                            o_res.pixel_index = r_led_cnt[PIX_IDX_W-1:0];
                            o_res.red         = n_partial[7:0];
                            o_res.green       = n_partial[15:8];
                            o_res.blue        = n_partial[23:16];
                        end
                        if (r_led_cnt != LED_CNT_SAT) begin
                            n_led_cnt = r_led_cnt + 1'b1;
                        end
                    end else begin
                        n_byte_in_led = r_byte_in_led + 1'b1;
                    end
                end
                n_remaining = r_remaining - 1'b1;
                w_finish    = (r_remaining == {{(LEN_W-1){1'b0}}, 1'b1});
            end
            default: n_hdr_pos = HDR_CHANNEL;
        endcase

        if (w_finish) begin
            if (w_status == ST_ACCEPTED) begin
                n_msg_cnt = r_msg_cnt + 1'b1;
            end
            n_hdr_pos               = HDR_CHANNEL;
            o_res.message_done      = 1'b1;
            o_res.message_status    = w_status;
            o_res.accepted_messages = n_msg_cnt;
        end

        o_res_valid = o_res.pixel_valid || o_res.message_done;
    end
endmodule

@@ rtl/pcsp_out_reg.sv @@
// Result register driving the output channel.
`timescale 1ns / 1ps
module pcsp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pcsp_pkg::t_result i_res,
    output logic              o_can_load,
    pcsp_result_if.source     o_result
);
    import pcsp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid             = r_valid;
    assign o_result.pixel_valid       = r_res.pixel_valid;
    assign o_result.pixel_index       = r_res.pixel_index;
    assign o_result.red               = r_res.red;
    assign o_result.green             = r_res.green;
    assign o_result.blue              = r_res.blue;
    assign o_result.message_done      = r_res.message_done;
    assign o_result.message_status    = r_res.message_status;
    assign o_result.accepted_messages = r_res.accepted_messages;
endmodule

@@ rtl/pixel_control_stream_parser.sv @@
// Top level of the pixel control stream parser.
`timescale 1ns / 1ps
`include "pixel_control_stream_parser_macros.svh"
// Usage:
//   i_byte carries the message stream, one byte per transaction: channel,
//   command, length high, length low, then the payload.
//   o_result carries one transaction per completed LED within the configured
//   count (pixel_valid) and one per completed message (message_done); both
//   may share a transaction on the last payload byte.
//   Bytes that complete neither produce no transaction.
//   Configuration: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
//   Registers: a byte passes two register stages (input byte, result) before
//   its result transaction becomes valid.
//   Throughput: one byte per cycle unless a held result stalls the parser, set
//   by the combinational parser logic between the input and result registers.
//   Stall: when o_result.ready is low the result is held; the input
//   register still takes one more byte if empty, then i_byte.ready drops.
//   Reset: synchronous, active low; parser returns to awaiting a channel
//   byte, counters clear, LED count 0, slots red/green/blue.
module pixel_control_stream_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pcsp_byte_if.sink                       i_byte,
    pcsp_result_if.source                   o_result
);
    import pcsp_pkg::*;

    t_byte_item w_item;
    t_result    w_res;
    logic       w_take;
    logic       w_res_valid;
    logic       w_can_load;

    pcsp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    pcsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_advance   (w_can_load),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    pcsp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take && w_res_valid),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_result   (o_result)
    );

    `PCSP_ASSERT_IMPL(a_result_nonempty, i_clk, i_rst_n, o_result.valid, o_result.pixel_valid || o_result.message_done, "result transaction carries neither pixel nor message end")
    `PCSP_ASSERT_IMPL(a_skip_no_pixel, i_clk, i_rst_n, o_result.valid && o_result.message_done && (o_result.message_status != ST_ACCEPTED), !o_result.pixel_valid, "skipped message emitted a pixel")
    `PCSP_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_take && w_res_valid, o_result.valid, "parsed result not presented")
endmodule

@@ test/tb.sv @@
// Testbench for the pixel control stream parser: message stream in, pixel writes and status out.
`timescale 1ns / 1ps
module tb;
    import pcsp_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pcsp_byte_if   byte_bus ();
    pcsp_result_if res_bus ();

    pixel_control_stream_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (byte_bus),
        .o_result    (res_bus)
    );

    // parser state mirrored by the testbench
    t_hdr_pos               hdr_pos       = HDR_CHANNEL;
    logic [7:0]             chan_byte     = '0;
    logic [7:0]             cmd_byte      = '0;
    logic [LEN_W-1:0]       bytes_left    = '0;
    logic [1:0]             led_byte_pos  = '0;
    logic [14:0]            led_number    = '0;
    logic [7:0]             rgb_acc [3]   = '{default: '0};
    logic [MSG_CNT_W-1:0]   good_messages = '0;
    logic [LED_CNT_W-1:0]   strip_length  = '0;
    t_slot                  slot_map [3]  = '{SLOT_RED, SLOT_GREEN, SLOT_BLUE};

    t_result awaited_reports [$];
    int      error_count   = 0;
    int      bytes_sent    = 0;
    int      cycle_count   = 0;
    bit      idle_en       = 1'b1;
    bit      long_hold_req = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_msg_status header_status();
        if (cmd_byte != 8'h00)
            return ST_BAD_CMD;
        if (chan_byte != 8'h00)
            return ST_BAD_CHAN;
        return ST_ACCEPTED;
    endfunction

    function automatic void close_message(inout t_result r);
        t_msg_status st;
        st = header_status();
        if (st == ST_ACCEPTED)
            good_messages = good_messages + 1;
        r.message_done      = 1'b1;
        r.message_status    = st;
        r.accepted_messages = good_messages;
        hdr_pos             = HDR_CHANNEL;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        t_result r;
        bit      emit;
        int      limit;
        r    = '0;
        emit = 1'b0;
        if (hdr_pos != HDR_PAYLOAD) begin
            case (hdr_pos)
                HDR_CHANNEL: chan_byte = b;
                HDR_COMMAND: cmd_byte = b;
                HDR_LEN_HI:  bytes_left = {b, 8'h00};
                default: begin
                    bytes_left[7:0] = b;
                    led_byte_pos    = '0;
                    led_number      = '0;
                    rgb_acc         = '{default: '0};
                end
            endcase
            if (hdr_pos == HDR_LEN_LO && bytes_left == '0) begin
                close_message(r);
                emit = 1'b1;
            end else begin
                hdr_pos = t_hdr_pos'(hdr_pos + 3'd1);
            end
        end else begin
            if (header_status() == ST_ACCEPTED) begin
                if (led_byte_pos == 2'd0)
                    rgb_acc = '{default: '0};
                if (slot_map[led_byte_pos] != SLOT_NONE)
                    rgb_acc[slot_map[led_byte_pos]] = b;
                led_byte_pos = led_byte_pos + 2'd1;
                if (led_byte_pos == 2'd3) begin
                    led_byte_pos = '0;
                    limit = (int'(strip_length) < MAX_LEDS) ? int'(strip_length) : MAX_LEDS;
                    if (int'(led_number) < limit) begin
                        r.pixel_valid = 1'b1;
                        r.pixel_index = led_number[PIX_IDX_W-1:0];
                        r.red         = rgb_acc[SLOT_RED];
                        r.green       = rgb_acc[SLOT_GREEN];
                        r.blue        = rgb_acc[SLOT_BLUE];
                        emit          = 1'b1;
                    end
                    if (led_number != 15'h7FFF)
                        led_number = led_number + 15'd1;
                end
            end
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
                close_message(r);
                emit = 1'b1;
            end
        end
        if (emit)
            awaited_reports = {awaited_reports, r};
    endfunction

    task automatic flag_error(input string what, input t_result want, input t_result seen);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t %s", $realtime, what);
            $display("  expected pix=%0b idx=%0d rgb=%02h/%02h/%02h done=%0b st=%0d cnt=%0d",
                     want.pixel_valid, want.pixel_index, want.red, want.green, want.blue,
                     want.message_done, want.message_status, want.accepted_messages);
            $display("  actual   pix=%0b idx=%0d rgb=%02h/%02h/%02h done=%0b st=%0d cnt=%0d",
                     seen.pixel_valid, seen.pixel_index, seen.red, seen.green, seen.blue,
                     seen.message_done, seen.message_status, seen.accepted_messages);
        end
    endtask

    // compare every result transaction with the oldest awaited one
    initial begin : result_checker
        t_result seen;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                seen.pixel_valid       = res_bus.pixel_valid;
                seen.pixel_index       = res_bus.pixel_index;
                seen.red               = res_bus.red;
                seen.green             = res_bus.green;
                seen.blue              = res_bus.blue;
                seen.message_done      = res_bus.message_done;
                seen.message_status    = res_bus.message_status;
                seen.accepted_messages = res_bus.accepted_messages;
                if (awaited_reports.size() == 0) begin
                    flag_error("result with nothing awaited", '0, seen);
                end else begin
                    want = awaited_reports.pop_front();
                    if (seen.pixel_valid !== want.pixel_valid
                        || seen.pixel_index !== want.pixel_index
                        || seen.red !== want.red
                        || seen.green !== want.green
                        || seen.blue !== want.blue
                        || seen.message_done !== want.message_done
                        || seen.message_status !== want.message_status
                        || seen.accepted_messages !== want.accepted_messages)
                        flag_error("result mismatch", want, seen);
                end
            end
        end
    end

    // result ready: random bursts of hold-off, plus one long hold on request
    initial begin : result_ready_driver
        int hold_left;
        hold_left     = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end else if (hold_left == 0 && idle_en && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 15);
            end
            if (i_rst_n !== 1'b1) begin
                res_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= value;
        do @(posedge i_clk); while (byte_bus.ready !== 1'b1);
        parse_byte(value);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] chan, input logic [7:0] cmd,
                               input logic [15:0] len);
        send_byte(chan);
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_message(input logic [7:0] chan, input logic [7:0] cmd,
                                input logic [15:0] len);
        send_header(chan, cmd, len);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        byte_bus.valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_LED_COUNT:   strip_length = value;
            CFG_SLOT_FIRST:  slot_map[0] = t_slot'(value[1:0]);
            CFG_SLOT_SECOND: slot_map[1] = t_slot'(value[1:0]);
            default:         slot_map[2] = t_slot'(value[1:0]);
        endcase
    endtask

    task automatic apply_config(input logic [LED_CNT_W-1:0] leds, input t_slot s0,
                                input t_slot s1, input t_slot s2);
        wait_idle();
        write_reg(CFG_LED_COUNT, leds);
        write_reg(CFG_SLOT_FIRST, CFG_DATA_W'(s0));
        write_reg(CFG_SLOT_SECOND, CFG_DATA_W'(s1));
        write_reg(CFG_SLOT_THIRD, CFG_DATA_W'(s2));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_slot any_slot();
        return t_slot'($urandom_range(0, 3));
    endfunction

    task automatic test_reset_state();
        send_header(8'h00, 8'h00, 16'h0000);
        send_message(8'h00, 8'h00, 16'd3);
    endtask

    task automatic test_pixel_basics();
        apply_config(11'd4, SLOT_RED, SLOT_GREEN, SLOT_BLUE);
        send_header(8'h00, 8'h00, 16'd7);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h3C);
        apply_config(11'd4, SLOT_BLUE, SLOT_GREEN, SLOT_RED);
        send_message(8'h00, 8'h00, 16'd6);
    endtask

    task automatic test_skipped_messages();
        send_message(8'h00, 8'h05, 16'd4);
        send_message(8'h09, 8'h00, 16'd2);
        send_message(8'hFF, 8'hFF, 16'd3);
        send_header(8'h00, 8'h01, 16'h0000);
        send_header(8'h80, 8'h00, 16'h0000);
        send_message(8'h80, 8'h00, 16'h0103);
    endtask

    task automatic test_slot_overlap();
        apply_config(11'd3, SLOT_GREEN, SLOT_GREEN, SLOT_NONE);
        send_message(8'h00, 8'h00, 16'd6);
        apply_config(11'd3, SLOT_NONE, SLOT_NONE, SLOT_NONE);
        send_message(8'h00, 8'h00, 16'd3);
        apply_config(11'd3, SLOT_BLUE, SLOT_RED, SLOT_BLUE);
        send_message(8'h00, 8'h00, 16'd9);
    endtask

    task automatic test_led_limit();
        apply_config(11'd1, SLOT_RED, SLOT_GREEN, SLOT_BLUE);
        send_message(8'h00, 8'h00, 16'd9);
        apply_config(11'h7FF, SLOT_RED, SLOT_GREEN, SLOT_BLUE);
        send_message(8'h00, 8'h00, 16'd12);
    endtask

    task automatic test_backpressure();
        apply_config(11'd1024, SLOT_RED, SLOT_GREEN, SLOT_BLUE);
        long_hold_req = 1'b1;
        send_message(8'h00, 8'h00, 16'd20);
        wait_idle();
        send_message(8'h00, 8'h00, 16'd6);
    endtask

    task automatic run_random_phase(input int budget, input logic [LED_CNT_W-1:0] leds,
                                    input t_slot s0, input t_slot s1, input t_slot s2);
        int first;
        int kind;
        int len;
        apply_config(leds, s0, s1, s2);
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 24);
            if (kind == 0)
                send_message(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), 16'(len));
            else if (kind == 1)
                send_message(8'($urandom_range(1, 255)), 8'h00, 16'(len));
            else
                send_message(8'h00, 8'h00, 16'(len));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(4, 11'($urandom_range(0, 12)), any_slot(), any_slot(), any_slot());
        run_random_phase(4, 11'd1024, SLOT_GREEN, SLOT_BLUE, SLOT_RED);
        run_random_phase(4, 11'h7FF, any_slot(), any_slot(), any_slot());
        wait_idle();
        idle_en = 1'b0;
        run_random_phase(4, 11'd5, SLOT_RED, SLOT_GREEN, SLOT_BLUE);
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_LED_COUNT;
        i_cfg_data         = '0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_pixel_basics();
        test_skipped_messages();
        test_slot_overlap();
        test_led_limit();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (awaited_reports.size() != 0) begin
            $display("%0d results never arrived", awaited_reports.size());
            error_count += awaited_reports.size();
        end
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/pcsp_pkg.sv
rtl/pcsp_byte_if.sv
rtl/pcsp_result_if.sv
rtl/pcsp_in_reg.sv
rtl/pcsp_parser.sv
rtl/pcsp_out_reg.sv
rtl/pixel_control_stream_parser.sv
test/tb.sv
